[src/huffman_code_checker_macros.svh]
// ----------------------------------------------------------------------------
// huffman code checker assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_CHECKER_MACROS_SVH
`define HUFFMAN_CODE_CHECKER_MACROS_SVH

`ifndef SYNTHESIS
`define HCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define HCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define HCC_ASSERT(lbl, prop, msg)
`define HCC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/hcc_pkg.sv]
// ----------------------------------------------------------------------------
// hcc_pkg
// shared constants, control struct and saturating cost helper
// ----------------------------------------------------------------------------
package hcc_pkg;

  localparam int unsigned MAX_SYMBOLS_DEF  = 64;
  localparam int unsigned MAX_CODE_LEN_DEF = 63;
  localparam int unsigned WEIGHT_BITS_DEF  = 16;

  localparam int unsigned WEIGHT_IN_W = 16;
  localparam int unsigned CODE_W      = 63;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned CS_ADDR_W   = 8;
  localparam int unsigned COST_W      = 28;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef struct packed {
    logic                 we;
    logic                 re;
    logic [CS_ADDR_W-1:0] addr;
    logic [CODE_W-1:0]    code;
    logic [LEN_W-1:0]     len;
  } cs_ctrl_t;

  function automatic logic [COST_W-1:0] sat_cost(input logic [COST_W:0] s);
    if (s[COST_W]) begin
      return COST_MAX;
    end
    return s[COST_W-1:0];
  endfunction

endpackage

[src/huffman_code_checker.sv]
// ----------------------------------------------------------------------------
// huffman_code_checker
// builds a huffman tree from symbol weights and reports its cost, then
// checks candidate code sets for optimal cost and the prefix property
//
//   channel | valid       | stall       | payload
//   in      | in_valid_i  | in_stall_o  | action, weight, code_bits, code_len, last
//   out     | out_valid_o | out_stall_i | kind, cost, accepted
//
// weight without last: written in idle; codeword: multiply, scan of stored codes, finish
// tree build: merge i (n..2n-2) scans nodes <i, writes sum, links mins via node port
// single-port node memory scan sets the build time, code memory scan the check
// reset clears counters, flags and control; memories need no clearing
// a pending result waits for out_stall_i low; the input stays stalled meanwhile
// ----------------------------------------------------------------------------
`include "huffman_code_checker_macros.svh"

module huffman_code_checker #(
  parameter int unsigned MAX_SYMBOLS  = hcc_pkg::MAX_SYMBOLS_DEF,
  parameter int unsigned MAX_CODE_LEN = hcc_pkg::MAX_CODE_LEN_DEF,
  parameter int unsigned WEIGHT_BITS  = hcc_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [hcc_pkg::WEIGHT_IN_W-1:0] weight_i,
  input  logic [hcc_pkg::CODE_W-1:0]    code_bits_i,
  input  logic [hcc_pkg::LEN_W-1:0]     code_len_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kind_o,
  output logic [hcc_pkg::COST_W-1:0]    cost_o,
  output logic                          accepted_o
);

  localparam int unsigned WB    = (WEIGHT_BITS < hcc_pkg::WEIGHT_IN_W) ?
                                  WEIGHT_BITS : hcc_pkg::WEIGHT_IN_W;
  localparam int unsigned NODES = 2 * MAX_SYMBOLS - 1;
  localparam int unsigned NA    = $clog2(NODES);
  localparam int unsigned NW    = WB + $clog2(MAX_SYMBOLS);
  localparam int unsigned SCW   = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned CCW   = $clog2(MAX_SYMBOLS + 2);
  localparam int unsigned MCL   = MAX_CODE_LEN;
  localparam int unsigned LW    = hcc_pkg::LEN_W;
  localparam int unsigned PW    = WB + LW;
  localparam int unsigned CW    = hcc_pkg::COST_W;
  localparam logic [LW-1:0] MCL_L = LW'(MAX_CODE_LEN);

  typedef enum logic [3:0] {
    S_IDLE, S_B_SCAN, S_B_WNEW, S_B_WM1, S_B_WM2, S_B_OUT,
    S_C_MUL, S_C_SCAN, S_C_FIN
  } state_e;

  state_e          state_q;
  logic [SCW-1:0]  sym_cnt_q;
  logic [CCW-1:0]  code_cnt_q;
  logic            done_q;
  logic [CW-1:0]   opt_q, cand_q;
  logic            conf_q;
  logic [NA-1:0]   i_q, end_q, iss_q, nidx_q;
  logic            nvld_q;
  logic [NW:0]     nrd_q;
  logic            h1_q, h2_q;
  logic [NA-1:0]   m1_q, m2_q;
  logic [NW-1:0]   w1_q, w2_q;
  logic [LW-1:0]   len_q;
  logic [MCL-1:0]  code_q;
  logic            last_q, use_w_q;
  logic [PW-1:0]   prod_q;
  logic [CCW-1:0]  lim_q, ciss_q;
  logic            cvld_q;
  logic            out_valid_q, kind_q, acc_q;
  logic [CW-1:0]   cost_q;

  logic [NW:0]     node_mem [NODES];
  logic            n_we, n_re;
  logic [NA-1:0]   n_waddr, n_raddr;
  logic [NW:0]     n_wdata;

  hcc_pkg::cs_ctrl_t cs_ctrl;
  logic              cs_hit;

  logic [SCW-1:0]  eff_cnt, cnt_new;
  logic [NW-1:0]   sum_w, rd_w;
  logic            rd_linked;
  logic [LW-1:0]   len_c;
  logic [MCL-1:0]  masked, aligned;
  logic            emit_ok;
  logic [CW-1:0]   cand_d;
  logic [CCW-1:0]  code_cnt_d;
  logic            verdict;
  logic            in_acc;
  logic [NA-1:0]   i_nx;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign emit_ok   = !out_valid_q || !out_stall_i;
  assign eff_cnt   = done_q ? '0 : sym_cnt_q;
  assign cnt_new   = (eff_cnt < SCW'(MAX_SYMBOLS)) ? eff_cnt + SCW'(1) : eff_cnt;
  assign sum_w     = NW'(w1_q + w2_q);
  assign rd_w      = nrd_q[NW-1:0];
  assign rd_linked = nrd_q[NW];
  assign i_nx      = i_q + NA'(1);
  assign len_c     = (code_len_i > MCL_L) ? MCL_L : code_len_i;
  assign masked    = code_bits_i[MCL-1:0] & ~({MCL{1'b1}} << len_c);
  assign aligned   = masked << (MCL_L - len_c);
  assign cand_d    = hcc_pkg::sat_cost({1'b0, cand_q} + (CW+1)'(prod_q));
  assign code_cnt_d = (code_cnt_q <= CCW'(MAX_SYMBOLS)) ? code_cnt_q + CCW'(1) : code_cnt_q;
  assign verdict   = done_q && (code_cnt_d == CCW'(sym_cnt_q)) && (cand_d == opt_q) && !conf_q;

  always_comb begin
    n_we    = 1'b0;
    n_re    = 1'b0;
    n_waddr = '0;
    n_raddr = '0;
    n_wdata = '0;
    cs_ctrl = '0;
    cs_ctrl.code = hcc_pkg::CODE_W'(code_q);
    cs_ctrl.len  = len_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && !action_i && (eff_cnt < SCW'(MAX_SYMBOLS))) begin
          n_we    = 1'b1;
          n_waddr = NA'(eff_cnt);
          n_wdata = {1'b0, NW'(weight_i[WB-1:0])};
        end
        if (in_acc && action_i && (code_cnt_q < CCW'(sym_cnt_q))) begin
          n_re    = 1'b1;
          n_raddr = NA'(code_cnt_q);
        end
      end
      S_B_SCAN: begin
        n_re    = (iss_q < i_q);
        n_raddr = iss_q;
      end
      S_B_WNEW: begin
        n_we    = 1'b1;
        n_waddr = i_q;
        n_wdata = {1'b0, sum_w};
      end
      S_B_WM1: begin
        n_we    = 1'b1;
        n_waddr = m1_q;
        n_wdata = {1'b1, w1_q};
      end
      S_B_WM2: begin
        n_we    = 1'b1;
        n_waddr = m2_q;
        n_wdata = {1'b1, w2_q};
      end
      S_C_SCAN: begin
        cs_ctrl.re   = (ciss_q < lim_q);
        cs_ctrl.addr = hcc_pkg::CS_ADDR_W'(ciss_q);
      end
      S_C_FIN: begin
        if ((!last_q || emit_ok) && (code_cnt_q < CCW'(MAX_SYMBOLS))) begin
          cs_ctrl.we   = 1'b1;
          cs_ctrl.addr = hcc_pkg::CS_ADDR_W'(code_cnt_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (n_we) begin
      node_mem[n_waddr] <= n_wdata;
    end
    if (n_re) begin
      nrd_q <= node_mem[n_raddr];
    end
  end

  hcc_code_store #(
    .MAX_SYMBOLS  (MAX_SYMBOLS),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_code_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cs_ctrl),
    .hit_o  (cs_hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sym_cnt_q   <= '0;
      code_cnt_q  <= '0;
      done_q      <= 1'b0;
      opt_q       <= '0;
      cand_q      <= '0;
      conf_q      <= 1'b0;
      i_q         <= '0;
      end_q       <= '0;
      iss_q       <= '0;
      nidx_q      <= '0;
      nvld_q      <= 1'b0;
      h1_q        <= 1'b0;
      h2_q        <= 1'b0;
      m1_q        <= '0;
      m2_q        <= '0;
      w1_q        <= '0;
      w2_q        <= '0;
      len_q       <= '0;
      code_q      <= '0;
      last_q      <= 1'b0;
      use_w_q     <= 1'b0;
      prod_q      <= '0;
      lim_q       <= '0;
      ciss_q      <= '0;
      cvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= 1'b0;
      cost_q      <= '0;
      acc_q       <= 1'b0;
    end else begin
      nvld_q <= n_re;
      nidx_q <= n_raddr;
      cvld_q <= cs_ctrl.re;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && !action_i) begin
            done_q    <= 1'b0;
            sym_cnt_q <= cnt_new;
            if (done_q) begin
              code_cnt_q <= '0;
              cand_q     <= '0;
              conf_q     <= 1'b0;
            end
            if (last_i) begin
              opt_q <= '0;
              iss_q <= '0;
              h1_q  <= 1'b0;
              h2_q  <= 1'b0;
              i_q   <= NA'(cnt_new);
              end_q <= NA'((32'(cnt_new) << 1) - 32'd1);
              if (cnt_new <= SCW'(1)) begin
                state_q <= S_B_OUT;
              end else begin
                state_q <= S_B_SCAN;
              end
            end
          end else if (in_acc) begin
            len_q   <= len_c;
            code_q  <= aligned;
            last_q  <= last_i;
            use_w_q <= (code_cnt_q < CCW'(sym_cnt_q));
            state_q <= S_C_MUL;
          end
        end
        S_B_SCAN: begin
          if (iss_q < i_q) begin
            iss_q <= iss_q + NA'(1);
          end
          if (nvld_q && !rd_linked) begin
            if (!h1_q) begin
              h1_q <= 1'b1;
              m1_q <= nidx_q;
              w1_q <= rd_w;
            end else if (!h2_q) begin
              h2_q <= 1'b1;
              if (rd_w < w1_q) begin
                m2_q <= m1_q;
                w2_q <= w1_q;
                m1_q <= nidx_q;
                w1_q <= rd_w;
              end else begin
                m2_q <= nidx_q;
                w2_q <= rd_w;
              end
            end else if (rd_w < w1_q) begin
              m2_q <= m1_q;
              w2_q <= w1_q;
              m1_q <= nidx_q;
              w1_q <= rd_w;
            end else if (rd_w < w2_q) begin
              m2_q <= nidx_q;
              w2_q <= rd_w;
            end
          end
          if ((iss_q == i_q) && !nvld_q) begin
            state_q <= S_B_WNEW;
          end
        end
        S_B_WNEW: begin
          opt_q   <= hcc_pkg::sat_cost({1'b0, opt_q} + (CW+1)'(sum_w));
          state_q <= S_B_WM1;
        end
        S_B_WM1: begin
          state_q <= S_B_WM2;
        end
        S_B_WM2: begin
          i_q   <= i_nx;
          iss_q <= '0;
          h1_q  <= 1'b0;
          h2_q  <= 1'b0;
          if (i_nx == end_q) begin
            state_q <= S_B_OUT;
          end else begin
            state_q <= S_B_SCAN;
          end
        end
        S_B_OUT: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            kind_q      <= 1'b0;
            cost_q      <= opt_q;
            acc_q       <= 1'b0;
            done_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_C_MUL: begin
          prod_q  <= use_w_q ? PW'(rd_w[WB-1:0]) * PW'(len_q) : '0;
          lim_q   <= (code_cnt_q < CCW'(MAX_SYMBOLS)) ? code_cnt_q : '0;
          ciss_q  <= '0;
          state_q <= S_C_SCAN;
        end
        S_C_SCAN: begin
          if (ciss_q < lim_q) begin
            ciss_q <= ciss_q + CCW'(1);
          end
          if (cs_hit) begin
            conf_q <= 1'b1;
          end
          if ((ciss_q == lim_q) && !cvld_q) begin
            state_q <= S_C_FIN;
          end
        end
        S_C_FIN: begin
          if (!last_q) begin
            cand_q     <= cand_d;
            code_cnt_q <= code_cnt_d;
            state_q    <= S_IDLE;
          end else if (emit_ok) begin
            out_valid_q <= 1'b1;
            kind_q      <= 1'b1;
            cost_q      <= cand_d;
            acc_q       <= verdict;
            cand_q      <= '0;
            code_cnt_q  <= '0;
            conf_q      <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign cost_o      = cost_q;
  assign accepted_o  = acc_q;

  `HCC_ASSERT(a_sym_cnt, sym_cnt_q <= SCW'(MAX_SYMBOLS), "symbol count overflow")
  `HCC_ASSERT(a_code_cnt, code_cnt_q <= CCW'(MAX_SYMBOLS + 1), "code count overflow")
  `HCC_ASSERT(a_acc_kind, !(out_valid_o && accepted_o) || kind_o, "accept on cost beat")
  `HCC_ASSERT(a_merge_idx, (state_q != S_B_SCAN) || (i_q < end_q), "merge index past end")

endmodule

[src/hcc_code_store.sv]
// ----------------------------------------------------------------------------
// hcc_code_store
// codeword memory (left aligned) with registered read and prefix compare
// ----------------------------------------------------------------------------
`include "huffman_code_checker_macros.svh"

module hcc_code_store #(
  parameter int unsigned MAX_SYMBOLS  = hcc_pkg::MAX_SYMBOLS_DEF,
  parameter int unsigned MAX_CODE_LEN = hcc_pkg::MAX_CODE_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hcc_pkg::cs_ctrl_t ctrl_i,
  output logic             hit_o
);

  localparam int unsigned CA  = $clog2(MAX_SYMBOLS);
  localparam int unsigned MCL = MAX_CODE_LEN;
  localparam int unsigned LW  = hcc_pkg::LEN_W;

  logic [LW+MCL-1:0] mem [MAX_SYMBOLS];
  logic [LW+MCL-1:0] rd_q;
  logic              vld_q;
  logic [MCL-1:0]    rd_code;
  logic [LW-1:0]     rd_len;
  logic [LW-1:0]     min_len;
  logic [MCL-1:0]    cmp_mask;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem[ctrl_i.addr[CA-1:0]] <= {ctrl_i.len, ctrl_i.code[MCL-1:0]};
    end
    if (ctrl_i.re) begin
      rd_q <= mem[ctrl_i.addr[CA-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ctrl_i.re;
    end
  end

  assign rd_code  = rd_q[MCL-1:0];
  assign rd_len   = rd_q[LW+MCL-1:MCL];
  assign min_len  = (ctrl_i.len < rd_len) ? ctrl_i.len : rd_len;
  assign cmp_mask = ~({MCL{1'b1}} >> min_len);
  assign hit_o    = vld_q && (((ctrl_i.code[MCL-1:0] ^ rd_code) & cmp_mask) == '0);

  `HCC_ASSERT(a_no_rw_same, !(ctrl_i.we && ctrl_i.re), "code store read and write together")
  `HCC_ASSERT(a_wr_range, !ctrl_i.we || (ctrl_i.addr < hcc_pkg::CS_ADDR_W'(MAX_SYMBOLS)),
    "code store write out of range")
  `HCC_ASSERT_NEXT(a_hit_vld, !ctrl_i.re, !hit_o)

endmodule
